@@ src/sptp_pkg.sv @@
// Slotted-page tuple placer: shared types, field widths and codes.
// No dependencies; used by the channel interfaces, the core and the testbench files.
`default_nettype none

package sptp_pkg;

    localparam int LEN_W  = 16;
    localparam int PAGE_W = 4;
    localparam int SLOT_W = 11;
    localparam int OFF_W  = 14;
    localparam int ADDR_W = 32;

    typedef enum logic [0:0] {
        CMD_APPEND  = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_PLACED  = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_TOO_BIG = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd              command;
        logic [LEN_W-1:0]  tuple_length;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] page_index;
        logic              new_page;
        logic [SLOT_W-1:0] slot_number;
        logic [OFF_W-1:0]  pointer_offset;
        logic [OFF_W-1:0]  tuple_offset;
        logic [ADDR_W-1:0] tuple_address;
        logic [OFF_W-1:0]  header_lower;
        logic [OFF_W-1:0]  header_upper;
    } t_rsp;

endpackage

`default_nettype wire

@@ src/sptp_if.sv @@
// Slotted-page tuple placer: valid/ready channels for request and result words.
// Depends on sptp_pkg for the payload types.
`default_nettype none

interface sptp_req_if;
    logic             valid;
    logic             ready;
    sptp_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sptp_rsp_if;
    logic             valid;
    logic             ready;
    sptp_pkg::t_rsp   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/slotted_page_tuple_placer_core.sv @@
// Slotted-page tuple placer core: aligns each tuple, allocates a line pointer and
// tuple space in the current page, opens the next page when it is full.
// An accepted word is registered in the input stage, then its result word in the result stage that drives o_rsp.
// Throughput: one word per cycle while o_rsp takes results; a stalled result still lets one word enter.
// Reset (synchronous, active low): page 0 with empty pointers, base address 0,
// no pending words; page 0 is not flagged for clearing until a restart word.
`default_nettype none

module slotted_page_tuple_placer_core #(
    parameter int PAGE_BYTES   = 8192,
    parameter int HEADER_BYTES = 24,
    parameter int PAGE_COUNT   = 16,
    parameter int ALIGN_BYTES  = 8,
    parameter int SLOT_BYTES   = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [sptp_pkg::ADDR_W-1:0]   i_cfg_wdata,
    sptp_req_if.sink                     i_req,
    sptp_rsp_if.source                   o_rsp
);
    import sptp_pkg::*;

    localparam int PTR_W     = $clog2(PAGE_BYTES + 1);
    localparam int PG_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int SUM_W     = LEN_W + 1;
    localparam int NEED_W    = SUM_W + 1;
    localparam int SHIFT     = SUM_W + $clog2(ALIGN_BYTES);
    localparam int RECIP_W   = SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint RECIP = ((64'd1 << SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int CAPACITY  = PAGE_BYTES - HEADER_BYTES;

    // input stage
    logic                 r_s1_vld;
    logic                 r_s1_restart;
    logic                 r_s1_big;
    logic [PTR_W-1:0]     r_s1_aligned;
    logic [PTR_W-1:0]     r_s1_need;

    // page state
    logic [ADDR_W-1:0]    r_base;
    logic [PG_W-1:0]      r_page;
    logic [ADDR_W-1:0]    r_page_off;
    logic [PTR_W-1:0]     r_lower;
    logic [PTR_W-1:0]     r_upper;
    logic [SLOT_W-1:0]    r_count;

    // result stage
    logic                 r_o_vld;
    t_rsp                 r_rsp;

    logic                 s2_go;
    logic                 s1_adv;

    logic [SUM_W-1:0]     len_sum;
    logic [PROD_W-1:0]    len_prod;
    logic [SUM_W-1:0]     len_quot;
    logic [SUM_W-1:0]     len_aligned;
    logic [NEED_W-1:0]    len_need;

    logic                 room_ok;
    logic                 last_page;
    logic [PG_W-1:0]      pl_page;
    logic [ADDR_W-1:0]    pl_off;
    logic [PTR_W-1:0]     pl_lower;
    logic [PTR_W-1:0]     pl_upper;
    logic [SLOT_W-1:0]    pl_count;
    logic [PTR_W-1:0]     new_lower;
    logic [PTR_W-1:0]     new_upper;

    logic [PG_W-1:0]      n_page;
    logic [ADDR_W-1:0]    n_page_off;
    logic [PTR_W-1:0]     n_lower;
    logic [PTR_W-1:0]     n_upper;
    logic [SLOT_W-1:0]    n_count;
    t_rsp                 n_rsp;

    assign s2_go       = r_s1_vld && (!r_o_vld || o_rsp.ready);
    assign s1_adv      = !r_s1_vld || s2_go;
    assign i_req.ready = s1_adv;
    assign o_rsp.valid = r_o_vld;
    assign o_rsp.data  = r_rsp;

    // round up to the alignment by reciprocal multiply
    assign len_sum     = SUM_W'(i_req.data.tuple_length) + SUM_W'(ALIGN_BYTES - 1);
    assign len_prod    = PROD_W'(len_sum) * PROD_W'(RECIP);
    assign len_quot    = SUM_W'(len_prod >> SHIFT);
    assign len_aligned = SUM_W'(len_quot * SUM_W'(ALIGN_BYTES));
    assign len_need    = NEED_W'(len_aligned) + NEED_W'(SLOT_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s1_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_req.valid) begin
            r_s1_restart <= (i_req.data.command == CMD_RESTART);
            r_s1_big     <= (i_req.data.command == CMD_APPEND) &&
                            (len_need > NEED_W'(CAPACITY));
            r_s1_aligned <= PTR_W'(len_aligned);
            r_s1_need    <= PTR_W'(len_need);
        end
    end

    // allocation
    assign room_ok   = (r_upper >= r_lower) && ((r_upper - r_lower) >= r_s1_need);
    assign last_page = (r_page >= PG_W'(PAGE_COUNT - 1));
    assign pl_page   = room_ok ? r_page  : r_page + PG_W'(1);
    assign pl_off    = room_ok ? r_page_off : r_page_off + ADDR_W'(PAGE_BYTES);
    assign pl_lower  = room_ok ? r_lower : PTR_W'(HEADER_BYTES);
    assign pl_upper  = room_ok ? r_upper : PTR_W'(PAGE_BYTES);
    assign pl_count  = room_ok ? r_count : '0;
    assign new_lower = pl_lower + PTR_W'(SLOT_BYTES);
    assign new_upper = pl_upper - r_s1_aligned;

    always_comb begin
        n_page     = r_page;
        n_page_off = r_page_off;
        n_lower    = r_lower;
        n_upper    = r_upper;
        n_count    = r_count;

        n_rsp                = '0;
        n_rsp.status         = STATUS_PLACED;
        n_rsp.page_index     = PAGE_W'({{PAGE_W{1'b0}}, r_page});
        n_rsp.header_lower   = OFF_W'({{OFF_W{1'b0}}, r_lower});
        n_rsp.header_upper   = OFF_W'({{OFF_W{1'b0}}, r_upper});

        if (r_s1_restart) begin
            n_page     = '0;
            n_page_off = '0;
            n_lower    = PTR_W'(HEADER_BYTES);
            n_upper    = PTR_W'(PAGE_BYTES);
            n_count    = '0;
            n_rsp.page_index    = '0;
            n_rsp.new_page      = 1'b1;
            n_rsp.tuple_address = r_base;
            n_rsp.header_lower  = OFF_W'({{OFF_W{1'b0}}, n_lower});
            n_rsp.header_upper  = OFF_W'({{OFF_W{1'b0}}, n_upper});
        end else if (r_s1_big) begin
            n_rsp.status = STATUS_TOO_BIG;
        end else if (!room_ok && last_page) begin
            n_rsp.status = STATUS_FULL;
        end else begin
            n_page     = pl_page;
            n_page_off = pl_off;
            n_lower    = new_lower;
            n_upper    = new_upper;
            n_count    = pl_count + SLOT_W'(1);
            n_rsp.page_index     = PAGE_W'({{PAGE_W{1'b0}}, pl_page});
            n_rsp.new_page       = !room_ok;
            n_rsp.slot_number    = pl_count;
            n_rsp.pointer_offset = OFF_W'({{OFF_W{1'b0}}, pl_lower});
            n_rsp.tuple_offset   = OFF_W'({{OFF_W{1'b0}}, new_upper});
            n_rsp.tuple_address  = r_base + pl_off + ADDR_W'(new_upper);
            n_rsp.header_lower   = OFF_W'({{OFF_W{1'b0}}, new_lower});
            n_rsp.header_upper   = OFF_W'({{OFF_W{1'b0}}, new_upper});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_page     <= '0;
            r_page_off <= '0;
            r_lower    <= PTR_W'(HEADER_BYTES);
            r_upper    <= PTR_W'(PAGE_BYTES);
            r_count    <= '0;
            r_o_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (s2_go) begin
                r_page     <= n_page;
                r_page_off <= n_page_off;
                r_lower    <= n_lower;
                r_upper    <= n_upper;
                r_count    <= n_count;
                r_o_vld    <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

`default_nettype wire

@@ tb/placement_checker.sv @@
`timescale 1ns / 1ps
// Tuple placement checker: watches the request and result channels of the placer core,
// predicts each result word from its own copy of the page state and compares field by field.
// Depends on sptp_pkg and the channel interfaces in sptp_if.
`default_nettype none

module placement_checker #(
    parameter int PAGE_BYTES   = 8192,
    parameter int HEADER_BYTES = 24,
    parameter int PAGE_COUNT   = 16,
    parameter int ALIGN_BYTES  = 8,
    parameter int SLOT_BYTES   = 4
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [sptp_pkg::ADDR_W-1:0] i_cfg_wdata,
    sptp_req_if                        req_ch,
    sptp_rsp_if                        rsp_ch,
    output int                         o_fail_count,
    output int                         o_pending
);
    import sptp_pkg::*;

    int unsigned page_now;
    int unsigned lower_now;
    int unsigned upper_now;
    int unsigned tuples_in_page;
    int unsigned base_now;
    int          mismatches;
    t_rsp        expected_placements[$];

    function automatic void open_page(int unsigned page);
        page_now       = page;
        lower_now      = HEADER_BYTES;
        upper_now      = PAGE_BYTES;
        tuples_in_page = 0;
    endfunction

    function automatic t_rsp placement_of(t_req w);
        t_rsp        r;
        int unsigned len;
        int unsigned aligned;
        int unsigned needed;
        r   = '0;
        len = 32'(w.tuple_length);
        if (w.command == CMD_RESTART) begin
            open_page(0);
            r.status        = STATUS_PLACED;
            r.new_page      = 1'b1;
            r.tuple_address = base_now;
            r.header_lower  = OFF_W'(lower_now);
            r.header_upper  = OFF_W'(upper_now);
            return r;
        end
        aligned = ((len + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        needed  = SLOT_BYTES + aligned;
        r.page_index   = PAGE_W'(page_now);
        r.header_lower = OFF_W'(lower_now);
        r.header_upper = OFF_W'(upper_now);
        if (needed > PAGE_BYTES - HEADER_BYTES) begin
            r.status = STATUS_TOO_BIG;
            return r;
        end
        if (upper_now < lower_now || upper_now - lower_now < needed) begin
            if (page_now + 1 >= PAGE_COUNT) begin
                r.status = STATUS_FULL;
                return r;
            end
            open_page(page_now + 1);
            r.new_page = 1'b1;
        end
        r.status         = STATUS_PLACED;
        r.page_index     = PAGE_W'(page_now);
        r.slot_number    = SLOT_W'(tuples_in_page);
        r.pointer_offset = OFF_W'(lower_now);
        lower_now        = lower_now + SLOT_BYTES;
        upper_now        = upper_now - aligned;
        tuples_in_page   = (tuples_in_page + 1) & 32'h7FF;
        r.tuple_offset   = OFF_W'(upper_now);
        r.tuple_address  = base_now + page_now * PAGE_BYTES + upper_now;
        r.header_lower   = OFF_W'(lower_now);
        r.header_upper   = OFF_W'(upper_now);
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            open_page(0);
            base_now = 0;
            expected_placements.delete();
        end else begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                got = rsp_ch.data;
                if (expected_placements.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, got 0x%0h", $time, got);
                end else begin
                    want = expected_placements.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("page_index", 32'(want.page_index), 32'(got.page_index));
                    check_field("new_page", 32'(want.new_page), 32'(got.new_page));
                    check_field("slot_number", 32'(want.slot_number), 32'(got.slot_number));
                    check_field("pointer_offset", 32'(want.pointer_offset),
                                32'(got.pointer_offset));
                    check_field("tuple_offset", 32'(want.tuple_offset), 32'(got.tuple_offset));
                    check_field("tuple_address", want.tuple_address, got.tuple_address);
                    check_field("header_lower", 32'(want.header_lower), 32'(got.header_lower));
                    check_field("header_upper", 32'(want.header_upper), 32'(got.header_upper));
                end
            end
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                expected_placements.push_back(placement_of(req_ch.data));
            if (i_cfg_we)
                base_now = i_cfg_wdata;
        end
        o_pending    <= expected_placements.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the tuple placer regression: clock, reset, request stimulus, result back-pressure,
// base address writes, watchdog and verdict. Depends on sptp_pkg, sptp_if,
// slotted_page_tuple_placer_core and placement_checker.
`default_nettype none

module testbench;
    import sptp_pkg::*;

    localparam int PAGE_BYTES   = 8192;
    localparam int HEADER_BYTES = 24;
    localparam int PAGE_COUNT   = 16;
    localparam int ALIGN_BYTES  = 8;
    localparam int SLOT_BYTES   = 4;
    localparam int FIT_MAX      = 8160;
    localparam int WORDS_PER_PHASE = 500;
    localparam int QUIET_LIMIT  = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_wdata;
    int                fail_count;
    int                pending;
    int                idle_pct;
    int                stall_pct;
    int                quiet_cycles;

    sptp_req_if req_ch ();
    sptp_rsp_if rsp_ch ();

    slotted_page_tuple_placer_core #(
        .PAGE_BYTES  (PAGE_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .PAGE_COUNT  (PAGE_COUNT),
        .ALIGN_BYTES (ALIGN_BYTES),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    placement_checker #(
        .PAGE_BYTES  (PAGE_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .PAGE_COUNT  (PAGE_COUNT),
        .ALIGN_BYTES (ALIGN_BYTES),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_placement_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .req_ch      (req_ch),
        .rsp_ch      (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_word(t_cmd cmd, logic [LEN_W-1:0] len);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.data.command      <= cmd;
        req_ch.data.tuple_length <= len;
        do begin
            @(negedge i_clk);
            taken = req_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_base(logic [ADDR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_word();
        int                sel;
        logic [LEN_W-1:0]  len;
        sel = int'($urandom_range(999));
        len = LEN_W'($urandom_range(65535));
        if (sel < 4)
            send_word(CMD_RESTART, len);
        else if (sel < 600)
            send_word(CMD_APPEND, LEN_W'($urandom_range(256)));
        else if (sel < 850)
            send_word(CMD_APPEND, LEN_W'($urandom_range(2048)));
        else if (sel < 950)
            send_word(CMD_APPEND, LEN_W'($urandom_range(FIT_MAX + 8)));
        else
            send_word(CMD_APPEND, len);
    endtask

    task automatic send_directed_words();
        send_word(CMD_APPEND, 16'd1);
        send_word(CMD_RESTART, 16'd0);
        send_word(CMD_APPEND, 16'd0);
        send_word(CMD_APPEND, 16'd8);
        send_word(CMD_APPEND, 16'd9);
        send_word(CMD_APPEND, LEN_W'(FIT_MAX));
        send_word(CMD_APPEND, LEN_W'(FIT_MAX + 1));
        send_word(CMD_APPEND, 16'hFFFF);
        repeat (PAGE_COUNT - 1) send_word(CMD_APPEND, LEN_W'(FIT_MAX));
        send_word(CMD_APPEND, 16'd0);
        send_word(CMD_APPEND, 16'd0);
        send_word(CMD_RESTART, 16'hFFFF);
    endtask

    initial begin
        logic [ADDR_W-1:0] bases [4];
        int                idle_set [4];
        int                stall_set [4];
        bases        = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFE_8000};
        bases[2]     = $urandom;
        idle_set     = '{0, 86, 0, 32};
        stall_set    = '{0, 0, 86, 32};
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            write_base(bases[phase]);
            idle_pct  = idle_set[phase];
            stall_pct = stall_set[phase];
            if (phase == 0)
                send_directed_words();
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n == WORDS_PER_PHASE / 2)
                    drain_results();
                send_random_word();
            end
        end

        drain_results();
        stall_pct = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
